// File: hw/rtl/igm_pkg.sv
`timescale 1ns / 1ps
package igm_pkg;
  localparam int MaxWidth = 1024;
  localparam int AddrW = $clog2(MaxWidth);
  localparam int WidthW = 11;
  localparam int HeightW = 16;
  localparam int ColW = 10;
  localparam logic [14:0] Sqrt2Q14 = 15'd23170;

  localparam logic RegImageWidth = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCalc,
    StRoot
  } igm_state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic start;
    logic shift;
    logic calc;
    logic root_step;
    logic root_done;
  } igm_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic has_result;
    logic root_last;
  } igm_stat_t;
endpackage

// File: hw/rtl/igm_ram.sv
`timescale 1ns / 1ps
module igm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hw/rtl/igm_ctrl.sv
`timescale 1ns / 1ps
module igm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              out_free_i,
  input  igm_pkg::igm_stat_t stat_i,
  output igm_pkg::igm_cmd_t  cmd_o,
  output logic              in_ready_o,
  output logic              out_load_o
);
  import igm_pkg::*;

  igm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Read lines, shift window, then for a pixel with a result compute gradients and run the root loop.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.start = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.shift = 1'b1;
        state_d = StCalc;
      end
      StCalc: begin
        if (stat_i.has_result) begin
          cmd_o.calc = 1'b1;
          state_d = StRoot;
        end else begin
          state_d = StIdle;
        end
      end
      StRoot: begin
        if (!stat_i.root_last) begin
          cmd_o.root_step = 1'b1;
        end else if (out_free_i) begin
          cmd_o.root_done = 1'b1;
          out_load_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// File: hw/rtl/igm_dp.sv
`timescale 1ns / 1ps
module igm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  igm_pkg::igm_cmd_t             cmd_i,
  input  logic [7:0]                    pixel_i,
  input  logic                          frame_start_i,
  input  logic [igm_pkg::WidthW-1:0]    image_width_i,
  input  logic [igm_pkg::HeightW-1:0]   image_height_i,
  output igm_pkg::igm_stat_t            stat_o,
  output logic [7:0]                    magnitude_o,
  output logic [igm_pkg::HeightW-1:0]   out_row_o,
  output logic [igm_pkg::ColW-1:0]      out_column_o,
  output logic                          last_of_frame_o
);
  import igm_pkg::*;

  logic [WidthW-1:0] w_use;
  logic [HeightW-1:0] h_use;
  logic [ColW:0] col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic [ColW:0] c_cur;
  logic [HeightW:0] r_cur;
  logic [HeightW-1:0] r_eff;
  logic [ColW:0] c_use_q;
  logic [HeightW-1:0] r_use_q;
  logic [7:0] pix_q;
  logic [7:0] up_rd, mid_rd;
  logic [7:0] win_q [9];
  logic res_q;
  logic [HeightW:0] r_nxt;
  logic [ColW:0] c_nxt;

  // Clamp register values to the range in use.
  always_comb begin
    if (image_width_i < WidthW'(3)) w_use = WidthW'(3);
    else if (image_width_i > WidthW'(MaxWidth)) w_use = WidthW'(MaxWidth);
    else w_use = image_width_i;
    h_use = (image_height_i < HeightW'(3)) ? HeightW'(3) : image_height_i;
  end

  // Position of the arriving pixel.
  always_comb begin
    c_cur = frame_start_i ? '0 : col_q;
    r_cur = frame_start_i ? '0 : {1'b0, row_q};
    if ({1'b0, c_cur} >= {1'b0, w_use}) begin
      c_cur = '0;
      r_cur = r_cur + 1'b1;
    end
    r_eff = (r_cur >= {1'b0, h_use}) ? '0 : r_cur[HeightW-1:0];
    c_nxt = c_cur + 1'b1;
    r_nxt = {1'b0, r_eff};
    col_d = c_nxt;
    row_d = r_eff;
    if ({1'b0, c_nxt} >= {1'b0, w_use}) begin
      col_d = '0;
      r_nxt = r_nxt + 1'b1;
      row_d = (r_nxt >= {1'b0, h_use}) ? '0 : r_nxt[HeightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      res_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      if (cmd_i.start) begin
        col_q <= col_d;
        row_q <= row_d;
        res_q <= (r_eff >= HeightW'(2)) && (c_cur >= (ColW+1)'(2));
      end
      if (cmd_i.shift) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k*3]   <= win_q[k*3+1];
          win_q[k*3+1] <= win_q[k*3+2];
        end
        win_q[2] <= up_rd;
        win_q[5] <= mid_rd;
        win_q[8] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pix_q <= pixel_i;
      c_use_q <= c_cur;
      r_use_q <= r_eff;
    end
  end

  // Line stores: read at start, write back during the window shift.
  igm_ram #(.Width(8), .Depth(MaxWidth)) u_upper (
    .clk_i, .we_i(cmd_i.shift), .waddr_i(c_use_q[AddrW-1:0]), .wdata_i(mid_rd),
    .raddr_i(c_cur[AddrW-1:0]), .rdata_o(up_rd)
  );
  igm_ram #(.Width(8), .Depth(MaxWidth)) u_middle (
    .clk_i, .we_i(cmd_i.shift), .waddr_i(c_use_q[AddrW-1:0]), .wdata_i(pix_q),
    .raddr_i(c_cur[AddrW-1:0]), .rdata_o(mid_rd)
  );

  // Gradients: integer parts scaled by sqrt2 in Q14 and by 2.
  logic signed [10:0] dv_d, dh_d;
  logic signed [9:0] ev_d, eh_d;
  logic signed [26:0] gv, gh;
  logic [25:0] av, ah;
  logic [51:0] sum;
  logic [23:0] q_d;
  always_comb begin
    dv_d = 11'(signed'({3'b0, win_q[6]})) - 11'(signed'({3'b0, win_q[0]}))
         + 11'(signed'({3'b0, win_q[8]})) - 11'(signed'({3'b0, win_q[2]}));
    dh_d = 11'(signed'({3'b0, win_q[2]})) - 11'(signed'({3'b0, win_q[0]}))
         + 11'(signed'({3'b0, win_q[8]})) - 11'(signed'({3'b0, win_q[6]}));
    ev_d = 10'(signed'({2'b0, win_q[7]})) - 10'(signed'({2'b0, win_q[1]}));
    eh_d = 10'(signed'({2'b0, win_q[5]})) - 10'(signed'({2'b0, win_q[3]}));
    gv = 27'(dv_d) * 27'(signed'({1'b0, Sqrt2Q14})) + (27'(ev_d) <<< 15);
    gh = 27'(dh_d) * 27'(signed'({1'b0, Sqrt2Q14})) + (27'(eh_d) <<< 15);
    av = gv[26] ? 26'(-gv) : gv[25:0];
    ah = gh[26] ? 26'(-gh) : gh[25:0];
  end

  // Gradient magnitudes registered, then squared, summed and shifted,
  // then a bit-per-cycle root from the top bit down.
  logic [25:0] av_q, ah_q;
  logic sq_pend_q;
  logic [51:0] sqv_q, sqh_q;
  logic sq_vld_q;
  logic [23:0] rq_q;
  logic [7:0] m_q;
  logic [3:0] bit_q;
  logic [7:0] trial;
  logic sat;
  always_comb begin
    sum = sqv_q + sqh_q;
    q_d = sum[51:28];
    trial = m_q | (8'd1 << (bit_q - 4'd1));
    sat = (rq_q >= 24'd65536);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_pend_q <= 1'b0;
      sq_vld_q <= 1'b0;
      bit_q <= '0;
    end else begin
      if (cmd_i.calc) begin
        sq_pend_q <= 1'b1;
        sq_vld_q <= 1'b1;
        bit_q <= 4'd8;
      end else if (cmd_i.root_step) begin
        if (sq_pend_q) begin
          sq_pend_q <= 1'b0;
        end else if (sq_vld_q) begin
          sq_vld_q <= 1'b0;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      av_q <= av;
      ah_q <= ah;
      m_q <= '0;
    end else if (cmd_i.root_step) begin
      if (sq_pend_q) begin
        sqv_q <= 52'(av_q) * 52'(av_q);
        sqh_q <= 52'(ah_q) * 52'(ah_q);
      end else if (sq_vld_q) begin
        rq_q <= q_d;
      end else if (!sat && (24'(trial) * 24'(trial) <= rq_q)) begin
        m_q <= trial;
      end
    end
  end

  assign stat_o.has_result = res_q;
  assign stat_o.root_last = !sq_pend_q && !sq_vld_q && (bit_q == 4'd0);

  // Output register loaded when the result is handed over.
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_done) begin
      magnitude_o <= sat ? 8'hff : m_q;
      out_row_o <= r_use_q - 1'b1;
      out_column_o <= ColW'(c_use_q - 1'b1);
      last_of_frame_o <= (r_use_q == h_use - 1'b1)
                      && ({1'b0, c_use_q} == {1'b0, w_use} - 1'b1);
    end
  end
endmodule

// File: hw/rtl/isotropic_gradient_magnitude_3x3_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// s_axis   in   tdata[7:0] pixel; tuser frame_start
// m_axis   out  tdata[33:0] magnitude, out_row, out_column; tlast last_of_frame
// cfg      in   index 0 image_width, 1 image_height
// A pixel without result is read and shifted only; one with result also runs
// the 8 root trials plus the square stage and sum stage of the shared datapath.
// Reset is asynchronous active low; line stores are not cleared.
// A result waits in the output register; the next pixel is taken meanwhile
// and the datapath stalls only when that register is still full.
module isotropic_gradient_magnitude_3x3_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // magnitude, out_row, out_column, zero pad
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import igm_pkg::*;

  logic [WidthW-1:0] width_q;
  logic [HeightW-1:0] height_q;
  igm_cmd_t cmd;
  igm_stat_t stat;
  logic out_load, vld_q;
  logic [7:0] mag;
  logic [HeightW-1:0] orow;
  logic [ColW-1:0] ocol;
  logic olast;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(1024);
      height_q <= HeightW'(768);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageWidth: width_q <= cfg_wdata_i[WidthW-1:0];
        RegImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  igm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .out_free_i(!vld_q || m_axis_tready),
    .stat_i(stat), .cmd_o(cmd), .in_ready_o(s_axis_tready), .out_load_o(out_load)
  );

  igm_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .pixel_i(s_axis_tdata), .frame_start_i(s_axis_tuser),
    .image_width_i(width_q), .image_height_i(height_q), .stat_o(stat),
    .magnitude_o(mag), .out_row_o(orow), .out_column_o(ocol), .last_of_frame_o(olast)
  );

  // Output valid flag; data is held in the datapath output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (out_load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = {6'b0, ocol, orow, mag};
  assign m_axis_tlast = olast;
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import igm_pkg::*;

  localparam int FrameMaxW = 1024;

  typedef struct {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_t;

  typedef struct {
    logic [7:0]  magnitude;
    logic [15:0] out_row;
    logic [9:0]  out_column;
    logic        last_of_frame;
  } grad_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // pixel
  logic        s_axis_tuser;   // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // magnitude, out_row, out_column, zero pad
  logic        m_axis_tlast;   // last_of_frame
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_wdata_i;

  isotropic_gradient_magnitude_3x3_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  pix_t  pixel_q[$];
  grad_t grad_q[$];
  int    err_cnt = 0;
  int    pix_cnt = 0;
  int    grad_cnt = 0;
  int    phase_cnt = 0;
  bit    bursts_on = 1'b1;

  // Shadow state of the filter.
  logic [10:0] sh_width;
  logic [15:0] sh_height;
  logic [7:0]  row_upper[FrameMaxW];
  logic [7:0]  row_middle[FrameMaxW];
  logic [7:0]  win[9];
  int          sh_col;
  int          sh_row;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int eff_width();
    int w;
    w = sh_width;
    if (w < 3) w = 3;
    if (w > FrameMaxW) w = FrameMaxW;
    return w;
  endfunction

  function automatic int eff_height();
    return (sh_height < 3) ? 3 : int'(sh_height);
  endfunction

  // Truncated square root, saturated to 255.
  function automatic logic [7:0] sat_root(longint unsigned q);
    logic [8:0] m;
    logic [8:0] c;
    m = 0;
    if (q >= 65536) return 8'hff;
    for (int b = 7; b >= 0; b--) begin
      c = m | (9'd1 << b);
      if (longint'(c) * longint'(c) <= q) m = c;
    end
    return m[7:0];
  endfunction

  // Advance the shadow filter by one pixel and queue the gradient it yields.
  task automatic predict_gradient(input logic [7:0] p, input logic fs);
    int w;
    int h;
    int c;
    int r;
    logic [7:0] up;
    logic [7:0] mid;
    longint gv;
    longint gh;
    longint unsigned s;
    grad_t g;
    w = eff_width();
    h = eff_height();
    if (fs) begin
      sh_col = 0;
      sh_row = 0;
    end
    c = sh_col;
    r = sh_row;
    if (c >= w) begin
      c = 0;
      r = r + 1;
    end
    if (r >= h) r = 0;
    up = row_upper[c];
    mid = row_middle[c];
    row_upper[c] = mid;
    row_middle[c] = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = p;
    if (r >= 2 && c >= 2) begin
      gv = longint'(Sqrt2Q14) * (longint'(win[6]) - win[0] + win[8] - win[2])
         + 32768 * (longint'(win[7]) - win[1]);
      gh = longint'(Sqrt2Q14) * (longint'(win[2]) - win[0] + win[8] - win[6])
         + 32768 * (longint'(win[5]) - win[3]);
      if (gv < 0) gv = -gv;
      if (gh < 0) gh = -gh;
      s = gv * gv + gh * gh;
      g.magnitude = sat_root(s >> 28);
      g.out_row = 16'(r - 1);
      g.out_column = 10'(c - 1);
      g.last_of_frame = (r == h - 1 && c == w - 1);
      grad_q.push_back(g);
    end
    c = c + 1;
    if (c >= w) begin
      c = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    sh_col = c;
    sh_row = r;
  endtask

  // Pixel driver with random idle bursts.
  int src_idle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    pix_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else begin
      nv = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_gradient(s_axis_tdata, s_axis_tuser);
        pix_cnt++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_idle > 0) begin
          src_idle--;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
          src_idle = $urandom_range(0, 6);
        end else if (pixel_q.size() > 0) begin
          it = pixel_q.pop_front();
          s_axis_tdata <= it.pixel;
          s_axis_tuser <= it.frame_start;
          nv = 1'b1;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Result monitor with random back-pressure bursts.
  int snk_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    grad_t g;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (grad_q.size() == 0) begin
          $error("unexpected result transaction: data %h last %b", m_axis_tdata,
                 m_axis_tlast);
          err_cnt++;
        end else begin
          g = grad_q.pop_front();
          grad_cnt++;
          if (m_axis_tdata[7:0] !== g.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", g.magnitude, m_axis_tdata[7:0]);
            err_cnt++;
          end
          if (m_axis_tdata[23:8] !== g.out_row) begin
            $error("out_row: expected %0d, actual %0d", g.out_row, m_axis_tdata[23:8]);
            err_cnt++;
          end
          if (m_axis_tdata[33:24] !== g.out_column) begin
            $error("out_column: expected %0d, actual %0d", g.out_column,
                   m_axis_tdata[33:24]);
            err_cnt++;
          end
          if (m_axis_tlast !== g.last_of_frame) begin
            $error("last_of_frame: expected %0b, actual %0b", g.last_of_frame, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_axis_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        snk_stall = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Wait until the filter has drained, then let its longest latency pass.
  task automatic wait_drained();
    while (pixel_q.size() > 0 || s_axis_tvalid || grad_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Write both frame size registers while the filter is idle.
  task automatic write_frame_size(input logic [10:0] w, input logic [15:0] h);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegImageWidth;
    cfg_wdata_i <= 16'(w);
    @(posedge clk_i);
    cfg_index_i <= RegImageHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_width = w;
    sh_height = h;
    phase_cnt++;
  endtask

  function automatic logic [7:0] make_pixel(input int mode, input logic [7:0] prev);
    int v;
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: begin
        v = int'(prev) + $urandom_range(0, 24) - 12;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
      end
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // Queue a run of raster pixels; the first one opens a frame.
  task automatic queue_frame(input int npix, input int mode, input bit noise);
    pix_t it;
    logic [7:0] prev;
    prev = 8'($urandom_range(0, 255));
    for (int i = 0; i < npix; i++) begin
      prev = make_pixel(mode, prev);
      it.pixel = prev;
      it.frame_start = (i == 0) || (noise && $urandom_range(0, 99) == 0);
      pixel_q.push_back(it);
    end
  endtask

  task automatic queue_pixels(input logic [7:0] p[], input bit fs);
    pix_t it;
    foreach (p[i]) begin
      it.pixel = p[i];
      it.frame_start = fs && (i == 0);
      pixel_q.push_back(it);
    end
  endtask

  // Stimulus.
  initial begin
    int rand_items;
    int w;
    int h;
    int rows;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegImageWidth;
    cfg_wdata_i = '0;
    sh_width = 11'd1024;
    sh_height = 16'd768;
    sh_col = 0;
    sh_row = 0;
    foreach (win[i]) win[i] = 8'd0;
    foreach (row_upper[i]) begin
      row_upper[i] = 8'd0;
      row_middle[i] = 8'd0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest frame: checkerboard, flat, then one bright edge that wraps into
    // the next frame without a frame start.
    write_frame_size(11'd3, 16'd3);
    queue_pixels('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b1);
    queue_pixels('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
    queue_pixels('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    // Register values below the minimum are clamped to three.
    write_frame_size(11'd0, 16'd0);
    queue_frame(27, 0, 1'b0);
    // Widths above the line buffer size clamp to the widest frame; part of
    // the first row must pass without any result.
    write_frame_size(11'h7ff, 16'd3);
    queue_frame(60, 1, 1'b0);

    // Random frame geometries and contents.
    rand_items = 0;
    while (rand_items < 700) begin
      if (rand_items > 560) bursts_on = 1'b0;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
      case ($urandom_range(0, 5))
        0: h = 16'hffff;
        1: h = $urandom_range(0, 2);
        default: h = $urandom_range(3, 8);
      endcase
      write_frame_size(11'(w), 16'(h));
      w = eff_width();
      h = eff_height();
      rows = (h > 8) ? $urandom_range(3, 6) : h * $urandom_range(1, 2);
      queue_frame(rows * w + $urandom_range(0, w - 1), $urandom_range(0, 2),
                  $urandom_range(0, 3) == 0);
      rand_items += rows * w;
    end

    wait_drained();
    $display("Covered %0d pixels in %0d frame geometries; %0d gradients checked.",
             pix_cnt, phase_cnt, grad_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/igm_pkg.sv
hw/rtl/igm_ram.sv
hw/rtl/igm_ctrl.sv
hw/rtl/igm_dp.sv
hw/rtl/isotropic_gradient_magnitude_3x3_core.sv
tb/sv/tb.sv
